[rtl/core/assert_macros.svh]
// assertion macros used by the correlator top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/pcpd_pkg.sv]
// types and constants of the preamble correlator
`default_nettype none
package pcpd_pkg;
	localparam int SAMPLE_W  = 12;
	localparam int TS_W      = 64;
	localparam int POW_W     = 64;
	localparam int CFG_W     = 59;
	localparam int CFG_IDX_W = 2;
	localparam int LEN_CFG_W = 7;
	localparam int HOLD_W    = 8;
	localparam int TAP_IDX_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_REF_LENGTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT      = 2'd2;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// sequencer controls for the shared complex mac
	typedef struct packed {
		logic clr;
		logic dat_vld;
		logic win_ok;
		logic sq_a;
		logic sq_b;
		logic sum;
	} pcpd_ctl_t;
endpackage
`default_nettype wire

[rtl/core/pcpd_ram.sv]
// generic single write, single registered read ram
`default_nettype none
module pcpd_ram #(
	parameter int W     = 24,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

[rtl/core/pcpd_cmac.sv]
// shared complex multiply-accumulate and power unit
`default_nettype none
module pcpd_cmac import pcpd_pkg::*; #(
	parameter int MAX_TAPS = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pcpd_ctl_t                  ctl,
	input  wire logic signed [SAMPLE_W-1:0] win_i,
	input  wire logic signed [SAMPLE_W-1:0] win_q,
	input  wire logic signed [SAMPLE_W-1:0] tap_i,
	input  wire logic signed [SAMPLE_W-1:0] tap_q,
	output logic             [POW_W-1:0]    power
);
	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_TAPS);
	localparam int SQ_W   = 2 * ACC_W;

	logic signed [SAMPLE_W-1:0] b_i, b_q;
	logic signed [PROD_W-1:0]   p_rr_s2, p_qq_s2, p_ri_s2, p_qr_s2;
	logic                       mul_vld_s2;
	logic signed [ACC_W-1:0]    acc_r_q, acc_i_q;
	logic signed [ACC_W-1:0]    sq_in;
	logic signed [SQ_W-1:0]     sq_prod;
	logic        [SQ_W-1:0]     sqa_q, sqb_q;
	logic        [SQ_W:0]       sq_sum;
	logic        [POW_W-1:0]    power_q;

	// never written window entries read as zero
	assign b_i = ctl.win_ok ? win_i : '0;
	assign b_q = ctl.win_ok ? win_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s2 <= 1'b0;
		end else begin
			mul_vld_s2 <= ctl.dat_vld;
		end
	end

	// conjugated tap times window sample
	always_ff @(posedge clk) begin
		p_rr_s2 <= tap_i * b_i;
		p_qq_s2 <= tap_q * b_q;
		p_ri_s2 <= tap_i * b_q;
		p_qr_s2 <= tap_q * b_i;
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_r_q <= '0;
			acc_i_q <= '0;
		end else if (mul_vld_s2) begin
			acc_r_q <= acc_r_q + ACC_W'(p_rr_s2) + ACC_W'(p_qq_s2);
			acc_i_q <= acc_i_q + ACC_W'(p_ri_s2) - ACC_W'(p_qr_s2);
		end
	end

	// one squarer, used for the real then the imaginary part
	assign sq_in   = ctl.sq_b ? acc_i_q : acc_r_q;
	assign sq_prod = sq_in * sq_in;
	assign sq_sum  = (SQ_W + 1)'(sqa_q) + (SQ_W + 1)'(sqb_q);

	always_ff @(posedge clk) begin
		if (ctl.sq_a) begin
			sqa_q <= sq_prod;
		end
		if (ctl.sq_b) begin
			sqb_q <= sq_prod;
		end
		if (ctl.sum) begin
			power_q <= POW_W'(sq_sum);
		end
	end

	assign power = power_q;
endmodule
`default_nettype wire

[rtl/core/preamble_correlator_peak_detect.sv]
// preamble correlator top: sequencer, window and tap memories, peak search
// a sample keeps in_stall high until the sequencer is idle again, so requests do not overlap,
// with len = ref_length clamped to 1..MAX_TAPS: len taps through the shared complex mac, the
// drain, squaring, sum and decide states; a tap load stays idle; a peak goes out in the decide
// state of the hold_count-th later sample not above it, waiting while out_stall holds the last
// async reset clears valid bits, search state; ref_length 64, hold 1; taps undefined till loaded
`default_nettype none
`include "assert_macros.svh"
module preamble_correlator_peak_detect import pcpd_pkg::*; #(
	parameter int MAX_TAPS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic        [CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [CFG_W-1:0]     cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        command,
	input  wire logic        [TAP_IDX_W-1:0] tap_index,
	input  wire logic signed [SAMPLE_W-1:0]  sample_i,
	input  wire logic signed [SAMPLE_W-1:0]  sample_q,
	input  wire logic        [TS_W-1:0]      timestamp,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic             [TS_W-1:0]      peak_timestamp
);
	localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int LEN_W = $clog2(MAX_TAPS + 1);
	localparam int RW    = 2 * SAMPLE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MAC,
		S_DRAIN1,
		S_DRAIN2,
		S_SQ_A,
		S_SQ_B,
		S_SUM,
		S_DECIDE
	} state_t;

	state_t                 state_q;
	logic                   out_valid_q;
	logic [TS_W-1:0]        match_ts_q;
	logic [LEN_CFG_W-1:0]   ref_len_q;
	logic [CFG_W-1:0]       thr_q;
	logic [HOLD_W-1:0]      hold_cnt_q;
	logic [AW-1:0]          wp_q;
	logic [AW-1:0]          pos_q;
	logic [LEN_W-1:0]       k_q;
	logic [LEN_W-1:0]       len_q;
	logic [MAX_TAPS-1:0]    win_vld_q;
	logic [POW_W-1:0]       best_power_q;
	logic [TS_W-1:0]        best_ts_q;
	logic [TS_W-1:0]        ts_q;
	logic [HOLD_W-1:0]      hold_rem_q;
	logic                   hold_act_q;
	logic                   dat_vld_s1;
	logic                   win_ok_s1;

	logic                   accept;
	logic [LEN_W-1:0]       len_eff;
	logic [AW:0]            start_sum;
	logic [AW-1:0]          start_pos;
	logic [AW-1:0]          pos_next;
	logic [AW-1:0]          wp_next;
	logic [HOLD_W-1:0]      hold_eff;
	logic [HOLD_W-1:0]      hold_dec;
	logic                   new_max;
	logic                   emit;
	logic                   emit_fire;
	logic                   tap_we;
	logic [RW-1:0]          win_rdata;
	logic [RW-1:0]          tap_rdata;
	logic [POW_W-1:0]       power;
	pcpd_ctl_t              ctl;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		if (ref_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(ref_len_q) > MAX_TAPS) begin
			len_eff = LEN_W'(MAX_TAPS);
		end else begin
			len_eff = LEN_W'(ref_len_q);
		end
	end

	// oldest sample in use, wrapped around the circular window
	assign start_sum = (AW + 1)'(wp_q) + (AW + 1)'(MAX_TAPS) - (AW + 1)'(len_eff - 1'b1);
	assign start_pos = (32'(start_sum) >= MAX_TAPS) ?
		AW'(start_sum - (AW + 1)'(MAX_TAPS)) : AW'(start_sum);
	assign pos_next  = (pos_q == AW'(MAX_TAPS - 1)) ? '0 : pos_q + 1'b1;
	assign wp_next   = (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
	assign hold_eff  = (hold_cnt_q == '0) ? HOLD_W'(1) : hold_cnt_q;
	assign hold_dec  = hold_rem_q - 1'b1;
	assign new_max   = power > best_power_q;
	assign emit      = !new_max && hold_act_q && (hold_dec == '0);
	assign emit_fire = (state_q == S_DECIDE) && emit && (!out_valid_q || !out_stall);
	assign tap_we    = accept && (command == CMD_LOAD) && (32'(tap_index) < MAX_TAPS);

	assign ctl.clr     = accept;
	assign ctl.dat_vld = dat_vld_s1;
	assign ctl.win_ok  = win_ok_s1;
	assign ctl.sq_a    = (state_q == S_SQ_A);
	assign ctl.sq_b    = (state_q == S_SQ_B);
	assign ctl.sum     = (state_q == S_SUM);

	pcpd_ram #(.W(RW), .DEPTH(MAX_TAPS), .AW(AW)) u_win_ram (
		.clk   (clk),
		.we    (accept && (command == CMD_SAMPLE)),
		.waddr (wp_q),
		.wdata ({sample_i, sample_q}),
		.raddr (pos_q),
		.rdata (win_rdata)
	);

	pcpd_ram #(.W(RW), .DEPTH(MAX_TAPS), .AW(AW)) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (AW'(tap_index)),
		.wdata ({sample_i, sample_q}),
		.raddr (k_q[AW-1:0]),
		.rdata (tap_rdata)
	);

	pcpd_cmac #(.MAX_TAPS(MAX_TAPS)) u_cmac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.win_i  (win_rdata[RW-1:SAMPLE_W]),
		.win_q  (win_rdata[SAMPLE_W-1:0]),
		.tap_i  (tap_rdata[RW-1:SAMPLE_W]),
		.tap_q  (tap_rdata[SAMPLE_W-1:0]),
		.power  (power)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			match_ts_q   <= '0;
			ref_len_q    <= LEN_CFG_W'(64);
			thr_q        <= '0;
			hold_cnt_q   <= HOLD_W'(1);
			wp_q         <= '0;
			pos_q        <= '0;
			k_q          <= '0;
			len_q        <= '0;
			win_vld_q    <= '0;
			best_power_q <= '0;
			best_ts_q    <= '0;
			ts_q         <= '0;
			hold_rem_q   <= '0;
			hold_act_q   <= 1'b0;
			dat_vld_s1   <= 1'b0;
			win_ok_s1    <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_REF_LENGTH: begin
						ref_len_q <= cfg_data[LEN_CFG_W-1:0];
					end
					REG_POWER_THRESHOLD: begin
						thr_q        <= cfg_data;
						best_power_q <= POW_W'(cfg_data);
						hold_rem_q   <= '0;
						hold_act_q   <= 1'b0;
						best_ts_q    <= '0;
					end
					REG_HOLD_COUNT: begin
						hold_cnt_q <= cfg_data[HOLD_W-1:0];
					end
					default: begin
					end
				endcase
			end
			dat_vld_s1 <= (state_q == S_MAC);
			win_ok_s1  <= win_vld_q[pos_q];
			unique case (state_q)
				S_IDLE: begin
					if (accept && (command == CMD_SAMPLE)) begin
						win_vld_q[wp_q] <= 1'b1;
						ts_q            <= timestamp;
						len_q           <= len_eff;
						pos_q           <= start_pos;
						k_q             <= '0;
						state_q         <= S_MAC;
					end
				end
				S_MAC: begin
					pos_q <= pos_next;
					k_q   <= k_q + 1'b1;
					if (k_q == len_q - 1'b1) begin
						state_q <= S_DRAIN1;
					end
				end
				S_DRAIN1: state_q <= S_DRAIN2;
				S_DRAIN2: state_q <= S_SQ_A;
				S_SQ_A:   state_q <= S_SQ_B;
				S_SQ_B:   state_q <= S_SUM;
				S_SUM:    state_q <= S_DECIDE;
				S_DECIDE: begin
					if (new_max) begin
						best_power_q <= power;
						hold_rem_q   <= hold_eff;
						hold_act_q   <= 1'b1;
						best_ts_q    <= ts_q;
						wp_q         <= wp_next;
						state_q      <= S_IDLE;
					end else if (emit) begin
						// wait for the output register to free up
						if (emit_fire) begin
							match_ts_q   <= best_ts_q;
							win_vld_q    <= '0;
							wp_q         <= '0;
							best_power_q <= POW_W'(thr_q);
							hold_rem_q   <= '0;
							hold_act_q   <= 1'b0;
							best_ts_q    <= '0;
							state_q      <= S_IDLE;
						end
					end else begin
						if (hold_act_q) begin
							hold_rem_q <= hold_dec;
						end
						wp_q    <= wp_next;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign peak_timestamp = match_ts_q;

	`ASSERT_ALWAYS(a_rise_from_decide, clk, arst_n, !$rose(out_valid_q) || $past(state_q == S_DECIDE))
	`ASSERT_ALWAYS(a_hold_nonzero, clk, arst_n, !hold_act_q || (hold_rem_q != '0))
	`ASSERT_NEXT(a_sample_starts_mac, clk, arst_n, accept && (command == CMD_SAMPLE), state_q == S_MAC)
	`ASSERT_ALWAYS(a_ptr_in_range, clk, arst_n, (32'(wp_q) < MAX_TAPS) && (32'(pos_q) < MAX_TAPS))
endmodule
`default_nettype wire
